[hw/rtl/glos_pkg.sv]
// Shared types and constants for the grid line-of-sight checker.
// No dependencies; every other source file uses this package.
package glos_pkg;

  localparam int CRD_W = 8;             // coordinate width
  localparam int CELL_W = 8;            // occupancy cell width
  localparam int ERR_W = 11;            // doubled Bresenham error, signed
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;
  localparam int MAP_W = 9;

  localparam int DEF_GRID_COLUMNS = 256;
  localparam int DEF_GRID_ROWS = 256;

  localparam logic [CELL_W-1:0] CELL_FREE = 8'd255;
  localparam logic [CELL_W-1:0] THRESH_RST = 8'd200;
  localparam logic [MAP_W-1:0] MAP_DIM_RST = 9'd256;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd2;

  typedef struct packed {
    logic clr_en;    // clearing sweep writes one entry
    logic wr_en;     // cell write item transferred
    logic q_start;   // query transferred, load walk setup
    logic walk;      // one step along the major axis
    logic load_out;  // move result into output register
  } glos_cmd_t;

  typedef struct packed {
    logic clr_last;  // sweep at last entry
    logic walk_last; // current step is the last one
    logic zero_len;  // incoming query has equal endpoints
  } glos_sts_t;

endpackage

[hw/rtl/glos_if.sv]
// Valid/ready channel interfaces: query/write input, result output, config writes.
// Depends on glos_pkg for field widths.
interface glos_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [glos_pkg::CRD_W-1:0]  cell_x;
  logic [glos_pkg::CRD_W-1:0]  cell_y;
  logic [glos_pkg::CELL_W-1:0] cell_value;
  logic [glos_pkg::CRD_W-1:0]  start_x;
  logic [glos_pkg::CRD_W-1:0]  start_y;
  logic [glos_pkg::CRD_W-1:0]  end_x;
  logic [glos_pkg::CRD_W-1:0]  end_y;

  modport source (output valid, operation, cell_x, cell_y, cell_value,
                  start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, operation, cell_x, cell_y, cell_value,
                start_x, start_y, end_x, end_y, output ready);
endinterface

interface glos_out_if;
  logic valid;
  logic ready;
  logic path_free;

  modport source (output valid, path_free, input ready);
  modport sink (input valid, path_free, output ready);
endinterface

interface glos_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [glos_pkg::CFG_IDX_W-1:0]  index;
  logic [glos_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/grid_line_of_sight_check.sv]
// Top level of the grid line-of-sight checker: controller plus datapath.
// Depends on glos_pkg, glos_if, glos_ctrl and glos_dp.
//
//   channel  modport  moves                                  ready
//   in_ch    sink     cell write or segment query            high in idle only
//   out_ch   source   path_free, one per query               from consumer
//   cfg_ch   sink     register index and data                always high
//
// A query walks its major-axis span dx (at most 255), reading one cell per
// cycle on the single grid read port, then passes a state for the last compare
// and one to hand off. A query with equal endpoints skips the walk and goes
// straight to hand-off. After reset a clearing pass writes 255 to all
// 2^(clog2(cols)+clog2(rows)) entries, one per cycle, with in_ch ready low.
// A finished result waits in the output register while the next item is taken;
// a later query stalls after its walk until that register is free.
module grid_line_of_sight_check #(
  parameter int GRID_COLUMNS = glos_pkg::DEF_GRID_COLUMNS,
  parameter int GRID_ROWS    = glos_pkg::DEF_GRID_ROWS
) (
  input logic        clk,
  input logic        rst_n,
  glos_in_if.sink    in_ch,
  glos_out_if.source out_ch,
  glos_cfg_if.sink   cfg_ch
);
  import glos_pkg::*;

  glos_cmd_t cmd;
  glos_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  glos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .sts       (sts),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.operation),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  glos_dp #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cell_x     (in_ch.cell_x),
    .cell_y     (in_ch.cell_y),
    .cell_value (in_ch.cell_value),
    .start_x    (in_ch.start_x),
    .start_y    (in_ch.start_y),
    .end_x      (in_ch.end_x),
    .end_y      (in_ch.end_y),
    .cfg_we     (cfg_ch.valid && cfg_ch.ready),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .path_free  (out_ch.path_free)
  );

endmodule

[hw/rtl/glos_ctrl.sv]
// Controller FSM: clearing sweep, item intake, line walk and result hand-off.
// Depends on glos_pkg; drives glos_dp through glos_cmd_t.
module glos_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  glos_pkg::glos_sts_t sts,
  input  logic                in_valid,
  input  logic                in_op,
  input  logic                out_ready,
  output logic                in_ready,
  output logic                out_valid,
  output glos_pkg::glos_cmd_t cmd
);
  import glos_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WALK  = 5'b00100,
    S_LAST  = 5'b01000,
    S_HOLD  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.q_start = 1'b1;
            state_nxt   = sts.zero_len ? S_HOLD : S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_last) state_nxt = S_LAST;
      end
      // last read returns here; blocked flag settles at this edge
      S_LAST: state_nxt = S_HOLD;
      S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/glos_dp.sv]
// Datapath: occupancy grid memory, config registers, Bresenham stepper, result flag.
// Depends on glos_pkg; sequenced by glos_ctrl.
module glos_dp #(
  parameter int GRID_COLUMNS = glos_pkg::DEF_GRID_COLUMNS,
  parameter int GRID_ROWS    = glos_pkg::DEF_GRID_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  glos_pkg::glos_cmd_t             cmd,
  output glos_pkg::glos_sts_t             sts,
  input  logic [glos_pkg::CRD_W-1:0]      cell_x,
  input  logic [glos_pkg::CRD_W-1:0]      cell_y,
  input  logic [glos_pkg::CELL_W-1:0]     cell_value,
  input  logic [glos_pkg::CRD_W-1:0]      start_x,
  input  logic [glos_pkg::CRD_W-1:0]      start_y,
  input  logic [glos_pkg::CRD_W-1:0]      end_x,
  input  logic [glos_pkg::CRD_W-1:0]      end_y,
  input  logic                            cfg_we,
  input  logic [glos_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [glos_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            path_free
);
  import glos_pkg::*;

  localparam int CW = $clog2(GRID_COLUMNS);
  localparam int RW = $clog2(GRID_ROWS);
  localparam int AW = CW + RW;
  localparam int DEPTH = 1 << AW;
  localparam int XW = (CW > CRD_W) ? CW : CRD_W;
  localparam int YW = (RW > CRD_W) ? RW : CRD_W;

  // config registers
  logic [CELL_W-1:0] thr_r;
  logic [MAP_W-1:0]  map_w_r, map_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THRESH_RST;
      map_w_r <= MAP_DIM_RST;
      map_h_r <= MAP_DIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD:  thr_r   <= cfg_data[CELL_W-1:0];
        CFG_MAP_WIDTH:  map_w_r <= cfg_data;
        CFG_MAP_HEIGHT: map_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clearing sweep address
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clr_en) clr_addr_r <= clr_addr_r + AW'(1);
  end

  // query setup from the incoming endpoints
  logic [CRD_W-1:0] adx, ady, a1, b1, a2, b2, x1, y1, x2, y2, dy0;
  logic             steep0;

  always_comb begin
    adx    = (end_x > start_x) ? end_x - start_x : start_x - end_x;
    ady    = (end_y > start_y) ? end_y - start_y : start_y - end_y;
    steep0 = ady > adx;
    a1 = steep0 ? start_y : start_x;
    b1 = steep0 ? start_x : start_y;
    a2 = steep0 ? end_y : end_x;
    b2 = steep0 ? end_x : end_y;
    if (a1 > a2) begin
      x1 = a2; y1 = b2; x2 = a1; y2 = b1;
    end else begin
      x1 = a1; y1 = b1; x2 = a2; y2 = b2;
    end
    dy0 = (y2 > y1) ? y2 - y1 : y1 - y2;
  end

  // walk registers
  logic [CRD_W-1:0]        x_r, y_r, x2_r, dx_r, dy_r;
  logic signed [ERR_W-1:0] err_r, err_sub, err_nxt;
  logic                    steep_r, ydown_r;

  always_comb begin
    err_sub = err_r - $signed(ERR_W'({dy_r, 1'b0}));
    err_nxt = err_sub;
    if (err_sub < 0) err_nxt = err_sub + $signed(ERR_W'({dx_r, 1'b0}));
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      x_r     <= x1;
      y_r     <= y1;
      x2_r    <= x2;
      dx_r    <= x2 - x1;
      dy_r    <= dy0;
      err_r   <= $signed(ERR_W'(x2 - x1));
      steep_r <= steep0;
      ydown_r <= !(y1 < y2);
    end else if (cmd.walk) begin
      x_r   <= x_r + CRD_W'(1);
      err_r <= err_nxt;
      if (err_sub < 0) y_r <= ydown_r ? y_r - CRD_W'(1) : y_r + CRD_W'(1);
    end
  end

  // current cell: column is the first index
  logic [CRD_W-1:0] col, row;
  logic [XW-1:0]    col_x;
  logic [YW-1:0]    row_x;
  logic             inmap;

  always_comb begin
    col   = steep_r ? y_r : x_r;
    row   = steep_r ? x_r : y_r;
    col_x = XW'(col);
    row_x = YW'(row);
    inmap = ({1'b0, col} < map_w_r) && ({1'b0, row} < map_h_r) &&
            (32'(col) < 32'(GRID_COLUMNS)) && (32'(row) < 32'(GRID_ROWS));
  end

  // grid memory: one write port, one registered read port
  logic [CELL_W-1:0] grid_mem [DEPTH];
  logic [CELL_W-1:0] rd_data_r, mem_wdata;
  logic [AW-1:0]     mem_waddr, rd_addr;
  logic [XW-1:0]     wcol_x;
  logic [YW-1:0]     wrow_x;
  logic              wr_in_grid, mem_we;

  always_comb begin
    wcol_x     = XW'(cell_x);
    wrow_x     = YW'(cell_y);
    wr_in_grid = (32'(cell_x) < 32'(GRID_COLUMNS)) && (32'(cell_y) < 32'(GRID_ROWS));
    mem_we     = cmd.clr_en || (cmd.wr_en && wr_in_grid);
    mem_waddr  = cmd.clr_en ? clr_addr_r : {wcol_x[CW-1:0], wrow_x[RW-1:0]};
    mem_wdata  = cmd.clr_en ? CELL_FREE : cell_value;
    rd_addr    = {col_x[CW-1:0], row_x[RW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
    rd_data_r <= grid_mem[rd_addr];
  end

  // obstacle test in the cycle after the read
  logic chk_r, blocked_r, path_free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r     <= 1'b0;
      blocked_r <= 1'b0;
    end else begin
      chk_r <= cmd.walk && inmap;
      if (cmd.q_start) blocked_r <= 1'b0;
      else if (chk_r && (rd_data_r < thr_r)) blocked_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) path_free_r <= !blocked_r;
  end

  assign path_free     = path_free_r;
  assign sts.clr_last  = &clr_addr_r;
  assign sts.walk_last = (({1'b0, x_r} + 9'd1) == {1'b0, x2_r});
  assign sts.zero_len  = (start_x == end_x) && (start_y == end_y);

endmodule

[hw/rtl/glos_checker.sv]
// Port-level assertions for grid_line_of_sight_check, bound to the top level.
// Depends on glos_pkg for the operation codes.
module glos_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_op,
  input logic out_valid,
  input logic out_ready,
  input logic path_free
);
  import glos_pkg::*;

  // queries taken but not yet delivered
  logic [1:0] pend_r;
  logic       q_xfer, o_xfer;

  assign q_xfer = in_valid && in_ready && (in_op == OP_QUERY);
  assign o_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 2'd0;
    else pend_r <= pend_r + 2'(q_xfer) - 2'(o_xfer);
  end

  a_clear_after_rst: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during grid clearing");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(path_free))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending query");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two queries in flight");

endmodule

bind grid_line_of_sight_check glos_checker u_glos_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_op     (in_ch.operation),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .path_free (out_ch.path_free)
);

[tb/glos_tb_pkg.sv]
// Item type and scoreboard for the grid line-of-sight checker testbench.
// Depends on glos_pkg; the scoreboard keeps its own grid, registers and result queue.
package glos_tb_pkg;
  import glos_pkg::*;

  localparam int COLS = DEF_GRID_COLUMNS;
  localparam int ROWS = DEF_GRID_ROWS;

  typedef struct packed {
    logic              operation;
    logic [CRD_W-1:0]  cell_x;
    logic [CRD_W-1:0]  cell_y;
    logic [CELL_W-1:0] cell_value;
    logic [CRD_W-1:0]  start_x;
    logic [CRD_W-1:0]  start_y;
    logic [CRD_W-1:0]  end_x;
    logic [CRD_W-1:0]  end_y;
  } glos_item_t;

  class los_board;
    logic [CELL_W-1:0] grid [COLS*ROWS];
    logic [CELL_W-1:0] threshold;
    logic [MAP_W-1:0]  map_w;
    logic [MAP_W-1:0]  map_h;
    logic              free_q[$];
    int unsigned       writes;
    int unsigned       queries;
    int unsigned       mismatches;

    function new();
      foreach (grid[i]) grid[i] = CELL_FREE;
      threshold = THRESH_RST;
      map_w = MAP_DIM_RST;
      map_h = MAP_DIM_RST;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_THRESHOLD: threshold = value[CELL_W-1:0];
        CFG_MAP_WIDTH: map_w = value;
        CFG_MAP_HEIGHT: map_h = value;
        default: ;
      endcase
    endfunction

    function bit blocks(int col, int row);
      if (col < 0 || row < 0) return 1'b0;
      if (col >= map_w || row >= map_h) return 1'b0;
      if (col >= COLS || row >= ROWS) return 1'b0;
      return grid[col*ROWS + row] < threshold;
    endfunction

    // Integer Bresenham, error term kept doubled; last major-axis cell not tested.
    function bit segment_free(int x1, int y1, int x2, int y2);
      int t, dx, dy, err, ystep, y;
      bit steep;
      if (x1 == x2 && y1 == y2) return 1'b1;
      steep = ((y2 > y1) ? y2 - y1 : y1 - y2) > ((x2 > x1) ? x2 - x1 : x1 - x2);
      if (steep) begin
        t = x1; x1 = y1; y1 = t;
        t = x2; x2 = y2; y2 = t;
      end
      if (x1 > x2) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
      end
      dx = x2 - x1;
      dy = (y2 > y1) ? y2 - y1 : y1 - y2;
      err = dx;
      ystep = (y1 < y2) ? 1 : -1;
      y = y1;
      for (int x = x1; x < x2; x++) begin
        if (steep ? blocks(y, x) : blocks(x, y)) return 1'b0;
        err -= 2 * dy;
        if (err < 0) begin
          y += ystep;
          err += 2 * dx;
        end
      end
      return 1'b1;
    endfunction

    function void note_item(glos_item_t it);
      if (it.operation == OP_WRITE) begin
        grid[int'(it.cell_x)*ROWS + int'(it.cell_y)] = it.cell_value;
        writes++;
      end else begin
        free_q.insert(free_q.size(),
                      segment_free(it.start_x, it.start_y, it.end_x, it.end_y));
        queries++;
      end
    endfunction

    function void check_result(logic path_free, realtime stamp);
      logic want;
      if (free_q.size() == 0) begin
        mismatches++;
        $display("%0.1f ns: path_free with no query pending, expected none, got %0b",
                 stamp, path_free);
        return;
      end
      want = free_q.pop_front();
      if (path_free !== want) begin
        mismatches++;
        $display("%0.1f ns: path_free mismatch, expected %0b, got %0b", stamp, want, path_free);
      end
    endfunction
  endclass

endpackage

[tb/tb_grid_line_of_sight_check.sv]
// Top-level testbench for grid_line_of_sight_check: drives cell writes, segment
// queries and register writes, and checks path_free. Depends on glos_pkg,
// glos_if, glos_tb_pkg and the RTL.
module tb_grid_line_of_sight_check;
  timeunit 1ns;
  timeprecision 1ps;

  import glos_pkg::*;
  import glos_tb_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_ITEMS = 92;
  localparam int HOLD_LEN = 700;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  glos_in_if  in_bus();
  glos_out_if out_bus();
  glos_cfg_if cfg_bus();

  los_board board;
  int  hold_cycles;
  int  stall_left;
  bit  quiet;
  int  settings_run;
  longint cycle_count;

  grid_line_of_sight_check u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // result sink: long hold first, then per-transfer stall
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_bus.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      board.check_result(out_bus.path_free, $realtime);
      stall_left = quiet ? 0 : int'($urandom_range(0, 18));
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic glos_item_t filler();
    glos_item_t it;
    it.operation = 1'($urandom_range(0, 1));
    it.cell_x = CRD_W'($urandom);
    it.cell_y = CRD_W'($urandom);
    it.cell_value = CELL_W'($urandom);
    it.start_x = CRD_W'($urandom);
    it.start_y = CRD_W'($urandom);
    it.end_x = CRD_W'($urandom);
    it.end_y = CRD_W'($urandom);
    return it;
  endfunction

  function automatic glos_item_t wr(int x, int y, int v);
    glos_item_t it;
    it = filler();
    it.operation = OP_WRITE;
    it.cell_x = CRD_W'(x);
    it.cell_y = CRD_W'(y);
    it.cell_value = CELL_W'(v);
    return it;
  endfunction

  function automatic glos_item_t seg(int sx, int sy, int ex, int ey);
    glos_item_t it;
    it = filler();
    it.operation = OP_QUERY;
    it.start_x = CRD_W'(sx);
    it.start_y = CRD_W'(sy);
    it.end_x = CRD_W'(ex);
    it.end_y = CRD_W'(ey);
    return it;
  endfunction

  function automatic logic [CRD_W-1:0] in_window(int base, int span);
    return CRD_W'(base + $urandom_range(0, span - 1));
  endfunction

  // writes and queries confined to a window so lines actually meet obstacles
  function automatic glos_item_t rand_item(int bx, int by, int span);
    glos_item_t it;
    int thr;
    it = filler();
    thr = int'(board.threshold);
    if ($urandom_range(0, 99) < 35) begin
      it.operation = OP_WRITE;
      it.cell_x = in_window(bx, span);
      it.cell_y = in_window(by, span);
      case ($urandom_range(0, 2))
        0: it.cell_value = CELL_FREE;
        1: it.cell_value = (thr > 0) ? CELL_W'($urandom_range(0, thr - 1)) : '0;
        default: it.cell_value = CELL_W'($urandom);
      endcase
    end else begin
      it.operation = OP_QUERY;
      if ($urandom_range(0, 9) != 0) begin
        it.start_x = in_window(bx, span);
        it.start_y = in_window(by, span);
        it.end_x = in_window(bx, span);
        it.end_y = in_window(by, span);
      end
    end
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic push_item(glos_item_t it, int gap);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.operation <= it.operation;
    in_bus.cell_x <= it.cell_x;
    in_bus.cell_y <= it.cell_y;
    in_bus.cell_value <= it.cell_value;
    in_bus.start_x <= it.start_x;
    in_bus.start_y <= it.start_y;
    in_bus.end_x <= it.end_x;
    in_bus.end_y <= it.end_y;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    board.note_item(it);
    @(negedge clk);
  endtask

  // leaves cfg valid high; the caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    board.set_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic settle_block();
    in_bus.valid <= 1'b0;
    while (board.free_q.size() != 0) @(posedge clk);
    // a trailing cell write has no result to wait for
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(int thr, int w, int h, int n);
    int span, bx, by;
    settle_block();
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(CFG_MAP_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_MAP_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    cfg_bus.valid <= 1'b0;
    settings_run++;
    span = 16;
    bx = 0;
    by = 0;
    for (int i = 0; i < n; i++) begin
      if (i % 25 == 0) begin
        case ($urandom_range(0, 3))
          0: span = 4;
          1: span = 16;
          2: span = 64;
          default: span = 256;
        endcase
        if (board.map_w < 256 && $urandom_range(0, 1) == 1) bx = 0;
        else bx = $urandom_range(0, 256 - span);
        if (board.map_h < 256 && $urandom_range(0, 1) == 1) by = 0;
        else by = $urandom_range(0, 256 - span);
        quiet = ($urandom_range(0, 3) == 0);
      end
      push_item(rand_item(bx, by, span), quiet ? 0 : int'($urandom_range(0, 18)));
    end
    quiet = 1'b0;
  endtask

  initial begin
    glos_item_t directed[$];

    board = new();
    hold_cycles = 0;
    stall_left = 0;
    quiet = 1'b0;
    settings_run = 1;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.operation = OP_WRITE;
    in_bus.cell_x = '0;
    in_bus.cell_y = '0;
    in_bus.cell_value = '0;
    in_bus.start_x = '0;
    in_bus.start_y = '0;
    in_bus.end_x = '0;
    in_bus.end_y = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_THRESHOLD;
    cfg_bus.data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part under reset register values
    directed.insert(directed.size(), seg(0, 0, 0, 0));          // equal endpoints
    directed.insert(directed.size(), seg(255, 255, 255, 255));
    directed.insert(directed.size(), seg(0, 0, 255, 255));      // full-span diagonal, free grid
    directed.insert(directed.size(), wr(10, 5, 199));           // just under threshold
    directed.insert(directed.size(), seg(0, 5, 20, 5));
    directed.insert(directed.size(), seg(0, 5, 10, 5));         // obstacle is untested last cell
    directed.insert(directed.size(), seg(20, 5, 10, 5));        // reversed: obstacle comes first
    directed.insert(directed.size(), wr(10, 5, 200));           // at threshold counts as free
    directed.insert(directed.size(), seg(0, 5, 20, 5));
    directed.insert(directed.size(), wr(3, 40, 0));
    directed.insert(directed.size(), seg(3, 0, 3, 80));         // steep
    directed.insert(directed.size(), seg(3, 80, 3, 0));
    directed.insert(directed.size(), seg(3, 40, 3, 0));
    directed.insert(directed.size(), wr(255, 255, 0));
    directed.insert(directed.size(), wr(0, 255, 255));
    directed.insert(directed.size(), seg(255, 255, 0, 0));
    directed.insert(directed.size(), seg(0, 255, 255, 0));      // descending minor axis
    directed.insert(directed.size(), wr(128, 127, 0));
    directed.insert(directed.size(), seg(0, 255, 255, 0));
    directed.insert(directed.size(), seg(7, 0, 200, 3));        // shallow slope
    directed.insert(directed.size(), wr(0, 0, 0));
    directed.insert(directed.size(), seg(1, 0, 0, 0));
    directed.insert(directed.size(), seg(0, 0, 0, 1));
    foreach (directed[i]) push_item(directed[i], int'($urandom_range(0, 18)));

    run_phase(THRESH_RST, MAP_DIM_RST, MAP_DIM_RST, PHASE_ITEMS);

    // hold results off long enough that the block backs up and stalls its input
    settle_block();
    @(posedge clk);
    hold_cycles = HOLD_LEN;
    @(negedge clk);
    for (int i = 0; i < 8; i++) push_item(seg($urandom_range(0, 15), $urandom_range(0, 15),
                                             $urandom_range(0, 15), $urandom_range(0, 15)), 0);

    run_phase(0, 256, 256, PHASE_ITEMS);
    run_phase(255, 256, 256, PHASE_ITEMS);
    run_phase(128, 1, 1, PHASE_ITEMS);
    run_phase(255, 0, 256, PHASE_ITEMS);
    run_phase(100, 511, 511, PHASE_ITEMS);
    run_phase(255, 256, 1, PHASE_ITEMS);
    run_phase($urandom_range(0, 255), $urandom_range(1, 256), $urandom_range(1, 256),
              PHASE_ITEMS);
    run_phase($urandom_range(0, 255), $urandom_range(1, 256), $urandom_range(1, 256),
              PHASE_ITEMS);

    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d cell writes and %0d segment queries over %0d register settings,",
             board.writes, board.queries, settings_run);
    $display("including a %0d-cycle result hold that backed up the input.", HOLD_LEN);
    if (board.mismatches == 0 && board.free_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[grid_line_of_sight_check.f]
hw/rtl/glos_pkg.sv
hw/rtl/glos_if.sv
hw/rtl/glos_ctrl.sv
hw/rtl/glos_dp.sv
hw/rtl/grid_line_of_sight_check.sv
hw/rtl/glos_checker.sv
tb/glos_tb_pkg.sv
tb/tb_grid_line_of_sight_check.sv
